@@ rtl/assert_macros.svh @@
// Assertion macros shared by the genotype packer RTL.
// Expects clk_i and rst_ni in the scope that uses SNP_ASSERT.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SNP_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the module's own clk_i / rst_ni.
`define SNP_ASSERT(name, prop, msg) \
  `SNP_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/snp_pkg.sv @@
// Package for the SNP genotype packer: sizes, codes, beat types, classifier.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package snp_pkg;

  localparam int MaxPeople = 256;
  localparam int AddrW     = (MaxPeople > 1) ? $clog2(MaxPeople) : 1;
  localparam int CntW      = $clog2(MaxPeople + 1);
  localparam int SlotW     = $clog2(MaxPeople + 4);
  localparam int CountW    = 10;
  localparam int CharW     = 7;

  localparam logic [CharW-1:0] MissingChar = 7'd48;
  localparam logic [CharW-1:0] NoneMajor   = 7'd49;
  localparam logic [CharW-1:0] NoneMinor   = 7'd50;

  // stored per-person class
  localparam logic [1:0] ClsMissing   = 2'd0;
  localparam logic [1:0] ClsHomFirst  = 2'd1;
  localparam logic [1:0] ClsHet       = 2'd2;
  localparam logic [1:0] ClsHomSecond = 2'd3;

  // emitted genotype code
  localparam logic [1:0] GenoMissing  = 2'd0;
  localparam logic [1:0] GenoHomMajor = 2'd1;
  localparam logic [1:0] GenoHet      = 2'd2;
  localparam logic [1:0] GenoHomMinor = 2'd3;

  // status
  localparam logic [1:0] ErrNone    = 2'd0;
  localparam logic [1:0] ErrThird   = 2'd1;
  localparam logic [1:0] ErrHalf    = 2'd2;
  localparam logic [1:0] ErrTooMany = 2'd3;

  // per-allele match tag
  localparam logic [2:0] TagMissing = 3'd0;
  localparam logic [2:0] TagFirst   = 3'd1;
  localparam logic [2:0] TagSecond  = 3'd3;
  localparam logic [2:0] TagThird   = 3'd7;

  typedef struct packed {
    logic [CharW-1:0] allele_one;
    logic [CharW-1:0] allele_two;
    logic             final_person;
  } item_t;

  typedef struct packed {
    logic [7:0]       packed_byte;
    logic [CharW-1:0] major_allele;
    logic [CharW-1:0] minor_allele;
    logic [1:0]       status;
    logic             end_of_run;
  } result_t;

  typedef struct packed {
    logic              f_vld;
    logic [CharW-1:0]  f;
    logic              s_vld;
    logic [CharW-1:0]  s;
    logic [CountW-1:0] c1;
    logic [CountW-1:0] c2;
  } allele_state_t;

  typedef struct packed {
    allele_state_t st;
    logic [2:0]    tag;
  } cls_res_t;

  // marker summary handed from loader to emitter
  typedef struct packed {
    logic [1:0]       err;
    logic             first_major;
    logic [CharW-1:0] major;
    logic [CharW-1:0] minor;
    logic [CntW-1:0]  people;
  } sum_t;

  typedef enum logic [1:0] {
    EmIdle,
    EmHead,
    EmWalk,
    EmDrain
  } emit_state_e;

  // Match one allele character against the seen alleles, updating counts.
  function automatic cls_res_t classify(allele_state_t st, logic [CharW-1:0] ch);
    cls_res_t r;
    r.st  = st;
    r.tag = TagThird;
    if (st.f_vld && ch == st.f) begin
      r.st.c1 = st.c1 + 1'b1;
      r.tag   = TagFirst;
    end else if (st.s_vld && ch == st.s) begin
      r.st.c2 = st.c2 + 1'b1;
      r.tag   = TagSecond;
    end else if (ch == MissingChar) begin
      r.tag = TagMissing;
    end else if (!st.f_vld) begin
      r.st.f_vld = 1'b1;
      r.st.f     = ch;
      r.st.c1    = st.c1 + 1'b1;
      r.tag      = TagFirst;
    end else if (!st.s_vld) begin
      r.st.s_vld = 1'b1;
      r.st.s     = ch;
      r.st.c2    = st.c2 + 1'b1;
      r.tag      = TagSecond;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/snp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module snp_ram #(
  parameter int Width = 2,
  parameter int Depth = 256
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                           wdata_i,
  input  wire logic                                       re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                                rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/snp_load.sv @@
// Loader: classifies one person per beat, keeps allele/count/error state.
// Depends on snp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module snp_load (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       take_i,
  input  wire snp_pkg::item_t             item_i,
  input  wire logic                       clr_i,
  output logic                            we_o,
  output logic [snp_pkg::AddrW-1:0]       waddr_o,
  output logic [1:0]                      wdata_o,
  output snp_pkg::sum_t                   sum_o
);
  import snp_pkg::*;

  allele_state_t    al_q, al_d;
  logic [CntW-1:0]  people_q, people_d;
  logic [1:0]       err_q, err_d;
  cls_res_t         ra, rb;
  allele_state_t    al_new;
  logic [1:0]       err_new, cls;
  logic             full;

  // priority: too many > third allele > half missing
  function automatic logic [1:0] err_rank(logic [1:0] e);
    logic [1:0] r;
    case (e)
      ErrTooMany: r = 2'd3;
      ErrThird:   r = 2'd2;
      ErrHalf:    r = 2'd1;
      default:    r = 2'd0;
    endcase
    return r;
  endfunction

  always_comb begin
    ra      = classify(al_q, item_i.allele_one);
    rb      = classify(ra.st, item_i.allele_two);
    full    = people_q >= CntW'(MaxPeople);
    al_new  = al_q;
    err_new = ErrNone;
    cls     = ClsMissing;
    if (full) begin
      err_new = ErrTooMany;
    end else if (ra.tag == TagThird) begin
      al_new  = ra.st;
      err_new = ErrThird;
    end else if (rb.tag == TagThird) begin
      al_new  = rb.st;
      err_new = ErrThird;
    end else begin
      al_new = rb.st;
      if (ra.tag == TagFirst && rb.tag == TagFirst) begin
        cls = ClsHomFirst;
      end else if ((ra.tag == TagFirst && rb.tag == TagSecond) ||
                   (ra.tag == TagSecond && rb.tag == TagFirst)) begin
        cls = ClsHet;
      end else if (ra.tag == TagSecond && rb.tag == TagSecond) begin
        cls = ClsHomSecond;
      end else if (!(ra.tag == TagMissing && rb.tag == TagMissing)) begin
        err_new = ErrHalf;
      end
    end

    al_d     = al_q;
    people_d = people_q;
    err_d    = err_q;
    if (clr_i) begin
      al_d     = '0;
      people_d = '0;
      err_d    = ErrNone;
    end else if (take_i) begin
      al_d     = al_new;
      people_d = full ? people_q : people_q + 1'b1;
      err_d    = (err_rank(err_new) > err_rank(err_q)) ? err_new : err_q;
    end

    we_o    = take_i && !full;
    waddr_o = people_q[AddrW-1:0];
    wdata_o = cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      al_q     <= '0;
      people_q <= '0;
      err_q    <= ErrNone;
    end else begin
      al_q     <= al_d;
      people_q <= people_d;
      err_q    <= err_d;
    end
  end

  // marker summary
  always_comb begin
    sum_o.err         = err_q;
    sum_o.people      = people_q;
    sum_o.first_major = al_q.c1 > al_q.c2;
    if (!al_q.f_vld) begin
      sum_o.major = NoneMajor;
      sum_o.minor = NoneMinor;
    end else if (!al_q.s_vld) begin
      sum_o.major = al_q.f;
      sum_o.minor = al_q.f;
    end else if (sum_o.first_major) begin
      sum_o.major = al_q.f;
      sum_o.minor = al_q.s;
    end else begin
      sum_o.major = al_q.s;
      sum_o.minor = al_q.f;
    end
  end

endmodule

`default_nettype wire

@@ rtl/snp_emit.sv @@
// Emitter: walks the class store one entry per cycle, packs four codes per
// byte and drives the result beats. Depends on snp_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module snp_emit (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 go_i,
  input  wire snp_pkg::sum_t        sum_i,
  input  wire logic [1:0]           rdata_i,
  output logic                      re_o,
  output logic [snp_pkg::AddrW-1:0] raddr_o,
  output logic                      clr_o,
  output logic                      busy_o,
  output logic                      done_o,
  output snp_pkg::result_t          res_o
);
  import snp_pkg::*;

  emit_state_e      state_q, state_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [SlotW-1:0] last_slot;
  logic [CntW-1:0]  people_m1;
  logic             p_vld_q, p_vld_d;
  logic             p_in_q, p_in_d;
  logic [SlotW-1:0] p_slot_q, p_slot_d;
  logic [5:0]       acc_q, acc_d;
  logic [1:0]       code;
  logic             done_d;
  result_t          res_d;

  assign people_m1 = sum_i.people - 1'b1;
  assign last_slot = SlotW'({people_m1[CntW-1:2], 2'b11});
  assign busy_o    = state_q != EmIdle;

  always_comb begin
    state_d  = state_q;
    slot_d   = slot_q;
    re_o     = 1'b0;
    raddr_o  = slot_q[AddrW-1:0];
    clr_o    = 1'b0;
    p_vld_d  = 1'b0;
    p_in_d   = 1'b0;
    p_slot_d = slot_q;
    done_d   = 1'b0;
    res_d    = '0;
    acc_d    = acc_q;
    code     = GenoMissing;

    // packing stage, one slot behind the read
    if (p_vld_q && p_in_q) begin
      case (rdata_i)
        ClsHet:       code = GenoHet;
        ClsHomFirst:  code = sum_i.first_major ? GenoHomMajor : GenoHomMinor;
        ClsHomSecond: code = sum_i.first_major ? GenoHomMinor : GenoHomMajor;
        default:      code = GenoMissing;
      endcase
    end
    if (p_vld_q) begin
      acc_d = {acc_q[3:0], code};
      if (p_slot_q[1:0] == 2'b11) begin
        done_d             = 1'b1;
        res_d.packed_byte  = {acc_q, code};
        res_d.major_allele = sum_i.major;
        res_d.minor_allele = sum_i.minor;
        res_d.status       = ErrNone;
        res_d.end_of_run   = p_slot_q == last_slot;
      end
    end

    case (state_q)
      EmIdle: begin
        if (go_i) begin
          state_d = EmHead;
        end
      end
      EmHead: begin
        if (sum_i.err != ErrNone) begin
          done_d           = 1'b1;
          res_d            = '0;
          res_d.status     = sum_i.err;
          res_d.end_of_run = 1'b1;
          clr_o            = 1'b1;
          state_d          = EmIdle;
        end else begin
          slot_d  = '0;
          state_d = EmWalk;
        end
      end
      EmWalk: begin
        re_o     = slot_q < SlotW'(sum_i.people);
        p_vld_d  = 1'b1;
        p_in_d   = re_o;
        p_slot_d = slot_q;
        slot_d   = slot_q + 1'b1;
        if (slot_q == last_slot) begin
          state_d = EmDrain;
        end
      end
      EmDrain: begin
        clr_o   = 1'b1;
        state_d = EmIdle;
      end
      default: state_d = EmIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EmIdle;
      slot_q  <= '0;
      p_vld_q <= 1'b0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      p_vld_q <= p_vld_d;
      done_o  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_in_q   <= p_in_d;
    p_slot_q <= p_slot_d;
    acc_q    <= acc_d;
    res_o    <= res_d;
  end

  `SNP_ASSERT(a_eor_idle, done_o && res_o.end_of_run |-> state_q == EmIdle, "end beat while walking")
  `SNP_ASSERT(a_eor_gap, done_o && res_o.end_of_run |=> !done_o, "beat after end of run")
  `SNP_ASSERT(a_clr_idle, clr_o |=> state_q == EmIdle, "marker cleared mid walk")

endmodule

`default_nettype wire

@@ rtl/snp_genotype_packer.sv @@
// SNP genotype packer: one person per cycle while loading, then a walk over
// the class store that emits 2-bit packed bytes. Results cannot be stalled:
// each one is on res_o for exactly one cycle, flagged by done_o, and must be
// taken then. A person is taken when start is high and busy is low; loading
// runs at one person per cycle with busy low. The person marked final_person
// starts emission: busy stays high through a header state, a walk of one slot per cycle
// (classes read from the single read port of the class store) and a drain
// state, and a byte beat appears for every fourth slot of the walk, the
// last one with end_of_run set. A marker with an error (third allele,
// half-missing genotype, more than MaxPeople people) gives a single status
// beat instead, with busy high for one cycle. Marker state clears itself
// with the last beat; the class store is never cleared, as only entries
// written in the current marker are read.
// Depends on snp_pkg, snp_ram, snp_load, snp_emit.
`timescale 1ns / 1ps
`default_nettype none

module snp_genotype_packer (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  wire snp_pkg::item_t   item_i,
  output logic                  busy,
  output logic                  done_o,
  output snp_pkg::result_t      res_o
);
  import snp_pkg::*;

  logic             take, go;
  logic             we, re;
  logic [AddrW-1:0] waddr, raddr;
  logic [1:0]       wdata, rdata;
  logic             clr;
  sum_t             sum;

  // a beat is taken when start is high and the emitter is idle
  assign take = start && !busy;
  assign go   = take && item_i.final_person;

  snp_load u_load (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .item_i  (item_i),
    .clr_i   (clr),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .sum_o   (sum)
  );

  // per-person class store, 2 bits per entry
  snp_ram #(
    .Width (2),
    .Depth (MaxPeople)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  snp_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (go),
    .sum_i   (sum),
    .rdata_i (rdata),
    .re_o    (re),
    .raddr_o (raddr),
    .clr_o   (clr),
    .busy_o  (busy),
    .done_o  (done_o),
    .res_o   (res_o)
  );

endmodule

`default_nettype wire
